>>> src/ddwo_pkg.sv
// Shared types, constants and tables for the wheel odometry block.
`timescale 1ns / 1ps
package ddwo_pkg;
    localparam int ANGLE_BITS = 16;
    localparam int TRIG_STEPS = 16;
    localparam int STEP_W     = (TRIG_STEPS > 1) ? $clog2(TRIG_STEPS) : 1;
    localparam int XW         = 46;
    localparam int ZW         = 34;
    localparam int CFG_IDX_W  = 8;

    localparam logic [29:0] INV_TWO_PI   = 30'd683565276;
    localparam logic [23:0] CORDIC_GAIN  = 24'd10188015;
    localparam logic [13:0] SPEED_SCALE  = 14'd15625;
    localparam logic [23:0] DPT_RESET    = 24'd44625;
    localparam logic [23:0] ITW_RESET    = 24'd71671;

    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_PER_TICK   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_TRACK_WIDTH = 8'd1;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_WHEEL, OP_MIX, OP_RAD, OP_ANG1, OP_ANG2, OP_HEAD,
        OP_MAG1, OP_MAG2, OP_CINIT, OP_CSTEP, OP_POSE, OP_SPD1, OP_SPD2,
        OP_DIV, OP_OUT
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic el_zero;
        logic div_busy;
    } status_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41721;
            5'd15: v = 32'd20860;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2607;
            5'd19: v = 32'd1303;
            5'd20: v = 32'd651;
            5'd21: v = 32'd325;
            5'd22: v = 32'd162;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction
endpackage

>>> src/ddwo_div.sv
// Radix-2 restoring divider with signed, saturated 32-bit quotient.
`timescale 1ns / 1ps
module ddwo_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [33:0] den,
    input  logic        neg,
    output logic        busy,
    output logic [31:0] q
);
    logic [33:0] rem_reg, den_reg;
    logic [32:0] num_reg, quo_reg;
    logic [5:0]  cnt_reg;
    logic        ovf_reg, neg_reg, busy_reg;
    logic [34:0] trial;
    logic [34:0] diff;

    assign trial = {rem_reg, num_reg[32]};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            rem_reg  <= {3'b0, num[63:33]};
            num_reg  <= num[32:0];
            den_reg  <= den;
            quo_reg  <= '0;
            neg_reg  <= neg;
            ovf_reg  <= {3'b0, num[63:33]} >= den;
        end else if (busy_reg) begin
            if (!diff[34]) begin
                rem_reg <= diff[33:0];
                quo_reg <= {quo_reg[31:0], 1'b1};
            end else begin
                rem_reg <= trial[33:0];
                quo_reg <= {quo_reg[31:0], 1'b0};
            end
            num_reg <= {num_reg[31:0], 1'b0};
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd32) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;

    always_comb begin
        if (neg_reg) begin
            if (ovf_reg || quo_reg > 33'h080000000) begin
                q = 32'h80000000;
            end else begin
                q = 32'(-quo_reg);
            end
        end else begin
            if (ovf_reg || quo_reg > 33'h07FFFFFFF) begin
                q = 32'h7FFFFFFF;
            end else begin
                q = quo_reg[31:0];
            end
        end
    end
endmodule

>>> src/ddwo_datapath.sv
// Odometry datapath: wheel math, heading, CORDIC rotation, pose, speeds.
`timescale 1ns / 1ps
module ddwo_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ddwo_pkg::cmd_t                  cmd,
    output ddwo_pkg::status_t               status,
    input  logic                            cfg_we,
    input  logic [ddwo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [23:0]                     cfg_data,
    input  logic signed [15:0]              s_left_tick_delta,
    input  logic signed [15:0]              s_right_tick_delta,
    input  logic [23:0]                     s_elapsed_us,
    output logic signed [39:0]              m_pose_x,
    output logic signed [39:0]              m_pose_y,
    output logic [15:0]                     m_heading_angle,
    output logic signed [31:0]              m_linear_speed,
    output logic signed [31:0]              m_angular_speed,
    output logic signed [47:0]              m_left_total,
    output logic signed [47:0]              m_right_total
);
    localparam int AB = ddwo_pkg::ANGLE_BITS;
    localparam int XW = ddwo_pkg::XW;
    localparam int ZW = ddwo_pkg::ZW;

    logic [23:0] dpt_reg, itw_reg;
    logic signed [15:0] lt_reg, rt_reg;
    logic [23:0] el_reg;
    logic signed [40:0] dl_reg, dr_reg, d_reg;
    logic signed [33:0] diff_reg;
    logic signed [57:0] rad_reg;
    logic [61:0] plo_reg;
    logic [31:0] phi_reg;
    logic [AB-1:0] newh_reg, heading_reg;
    logic signed [45:0] mh_reg;
    logic [43:0] mlo_reg;
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic signed [39:0] px_reg, py_reg;
    logic signed [47:0] lc_reg, rc_reg;
    logic signed [55:0] nlin_reg;
    logic signed [64:0] nang_reg;

    logic signed [41:0] sum42, dif42;
    logic [63:0] prod, rnd;
    logic [AB-1:0] dang;
    logic signed [65:0] msum;
    logic signed [XW-1:0] mag;
    logic [31:0] a32;
    logic signed [XW-1:0] xs, ys, xr, yr;
    logic signed [ZW-1:0] at;
    logic signed [50:0] rcl;
    logic [63:0] lin_mag, ang_mag;
    logic div_start, lin_busy, ang_busy;
    logic [31:0] lin_q, ang_q;
    logic [31:0] hw;
    logic signed [XW-1:0] xinc_w, yinc_w;

    assign sum42 = {dl_reg[40], dl_reg} + {dr_reg[40], dr_reg};
    assign dif42 = {dr_reg[40], dr_reg} - {dl_reg[40], dl_reg};
    assign prod  = {2'b0, plo_reg} + {phi_reg, 32'b0};
    assign rnd   = prod + (64'd1 << (63 - AB));
    assign dang  = rnd[63 -: AB];
    assign msum  = ($signed({mh_reg, 20'b0})) + $signed({22'b0, mlo_reg});
    assign mag   = XW'($signed(msum[65:24]));
    assign a32   = 32'(newh_reg) << (32 - AB);
    assign xs    = x_reg >>> cmd.step;
    assign ys    = y_reg >>> cmd.step;
    assign at    = $signed({2'b0, ddwo_pkg::atan_turn(5'(cmd.step))});
    assign xr    = x_reg + XW'(128);
    assign yr    = y_reg + XW'(128);
    assign xinc_w = xr >>> 8;
    assign yinc_w = yr >>> 8;
    assign hw    = 32'(heading_reg) << (32 - AB);

    always_comb begin
        if (rad_reg > 58'sh2000000000000) begin
            rcl = 51'sh2000000000000;
        end else if (rad_reg < -58'sh2000000000000) begin
            rcl = -51'sh2000000000000;
        end else begin
            rcl = rad_reg[50:0];
        end
    end

    assign lin_mag   = nlin_reg[55] ? 64'(-nlin_reg) : 64'(nlin_reg);
    assign ang_mag   = nang_reg[64] ? 64'(-nang_reg) : 64'(nang_reg);
    assign div_start = (cmd.op == ddwo_pkg::OP_DIV);

    ddwo_div u_div_lin (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(lin_mag),
        .den({8'b0, el_reg, 2'b0}), .neg(nlin_reg[55]), .busy(lin_busy), .q(lin_q)
    );

    ddwo_div u_div_ang (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(ang_mag),
        .den({el_reg, 10'b0}), .neg(nang_reg[64]), .busy(ang_busy), .q(ang_q)
    );

    assign status.el_zero  = (el_reg == '0);
    assign status.div_busy = lin_busy | ang_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dpt_reg     <= ddwo_pkg::DPT_RESET;
            itw_reg     <= ddwo_pkg::ITW_RESET;
            px_reg      <= '0;
            py_reg      <= '0;
            heading_reg <= '0;
            lc_reg      <= '0;
            rc_reg      <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == ddwo_pkg::REG_DISTANCE_PER_TICK) begin
                    dpt_reg <= cfg_data;
                end else if (cfg_index == ddwo_pkg::REG_INVERSE_TRACK_WIDTH) begin
                    itw_reg <= cfg_data;
                end
            end
            case (cmd.op)
                ddwo_pkg::OP_LOAD: begin
                    lt_reg <= s_left_tick_delta;
                    rt_reg <= s_right_tick_delta;
                    el_reg <= s_elapsed_us;
                end
                ddwo_pkg::OP_WHEEL: begin
                    dl_reg <= lt_reg * $signed({1'b0, dpt_reg});
                    dr_reg <= rt_reg * $signed({1'b0, dpt_reg});
                    lc_reg <= lc_reg + 48'(lt_reg);
                    rc_reg <= rc_reg + 48'(rt_reg);
                end
                ddwo_pkg::OP_MIX: begin
                    d_reg    <= sum42[41:1];
                    diff_reg <= dif42[41:8];
                end
                ddwo_pkg::OP_RAD: begin
                    rad_reg <= diff_reg * $signed({1'b0, itw_reg});
                end
                ddwo_pkg::OP_ANG1: begin
                    plo_reg <= rad_reg[31:0] * ddwo_pkg::INV_TWO_PI;
                end
                ddwo_pkg::OP_ANG2: begin
                    phi_reg <= 32'({{6{rad_reg[57]}}, rad_reg[57:32]} * ddwo_pkg::INV_TWO_PI);
                end
                ddwo_pkg::OP_HEAD: begin
                    newh_reg <= heading_reg + dang;
                end
                ddwo_pkg::OP_MAG1: begin
                    mh_reg <= $signed(d_reg[40:20]) * $signed({1'b0, ddwo_pkg::CORDIC_GAIN});
                end
                ddwo_pkg::OP_MAG2: begin
                    mlo_reg <= d_reg[19:0] * ddwo_pkg::CORDIC_GAIN;
                end
                ddwo_pkg::OP_CINIT: begin
                    z_reg <= $signed({4'b0, a32[29:0]});
                    case (a32[31:30])
                        2'd0: begin x_reg <= mag;  y_reg <= '0;   end
                        2'd1: begin x_reg <= '0;   y_reg <= mag;  end
                        2'd2: begin x_reg <= -mag; y_reg <= '0;   end
                        default: begin x_reg <= '0; y_reg <= -mag; end
                    endcase
                end
                ddwo_pkg::OP_CSTEP: begin
                    if (!z_reg[ZW-1]) begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - at;
                    end else begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + at;
                    end
                end
                ddwo_pkg::OP_POSE: begin
                    if (d_reg != '0) begin
                        px_reg <= px_reg + 40'(xinc_w);
                        py_reg <= py_reg + 40'(yinc_w);
                    end
                    heading_reg <= newh_reg;
                end
                ddwo_pkg::OP_SPD1: begin
                    nlin_reg <= d_reg * $signed({1'b0, ddwo_pkg::SPEED_SCALE});
                end
                ddwo_pkg::OP_SPD2: begin
                    nang_reg <= rcl * $signed({1'b0, ddwo_pkg::SPEED_SCALE});
                end
                ddwo_pkg::OP_OUT: begin
                    m_pose_x        <= px_reg;
                    m_pose_y        <= py_reg;
                    m_heading_angle <= hw[31:16];
                    m_linear_speed  <= (el_reg == '0) ? '0 : $signed(lin_q);
                    m_angular_speed <= (el_reg == '0) ? '0 : $signed(ang_q);
                    m_left_total    <= lc_reg;
                    m_right_total   <= rc_reg;
                end
                default: begin
                end
            endcase
        end
    end
endmodule

>>> src/ddwo_ctrl.sv
// Sequencer for the odometry datapath and the result handshake.
`timescale 1ns / 1ps
module ddwo_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output ddwo_pkg::cmd_t    cmd,
    input  ddwo_pkg::status_t status
);
    typedef enum logic [4:0] {
        S_IDLE, S_WHEEL, S_MIX, S_RAD, S_ANG1, S_ANG2, S_HEAD, S_MAG1, S_MAG2,
        S_CINIT, S_CORD, S_POSE, S_SPD1, S_SPD2, S_DIV, S_DIVW, S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic [ddwo_pkg::STEP_W-1:0] step_reg, step_next;
    logic m_valid_reg, m_valid_next;
    logic out_load;

    assign out_load = (state_reg == S_FIN) && (!m_valid_reg || m_ready);
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        cmd.op       = ddwo_pkg::OP_NONE;
        cmd.step     = step_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = ddwo_pkg::OP_LOAD;
                    state_next = S_WHEEL;
                end
            end
            S_WHEEL: begin cmd.op = ddwo_pkg::OP_WHEEL; state_next = S_MIX;  end
            S_MIX:   begin cmd.op = ddwo_pkg::OP_MIX;   state_next = S_RAD;  end
            S_RAD:   begin cmd.op = ddwo_pkg::OP_RAD;   state_next = S_ANG1; end
            S_ANG1:  begin cmd.op = ddwo_pkg::OP_ANG1;  state_next = S_ANG2; end
            S_ANG2:  begin cmd.op = ddwo_pkg::OP_ANG2;  state_next = S_HEAD; end
            S_HEAD:  begin cmd.op = ddwo_pkg::OP_HEAD;  state_next = S_MAG1; end
            S_MAG1:  begin cmd.op = ddwo_pkg::OP_MAG1;  state_next = S_MAG2; end
            S_MAG2:  begin cmd.op = ddwo_pkg::OP_MAG2;  state_next = S_CINIT; end
            S_CINIT: begin
                cmd.op     = ddwo_pkg::OP_CINIT;
                step_next  = '0;
                state_next = S_CORD;
            end
            S_CORD: begin
                cmd.op = ddwo_pkg::OP_CSTEP;
                if (step_reg == ddwo_pkg::STEP_W'(ddwo_pkg::TRIG_STEPS - 1)) begin
                    state_next = S_POSE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_POSE: begin
                cmd.op     = ddwo_pkg::OP_POSE;
                state_next = status.el_zero ? S_FIN : S_SPD1;
            end
            S_SPD1: begin cmd.op = ddwo_pkg::OP_SPD1; state_next = S_SPD2; end
            S_SPD2: begin cmd.op = ddwo_pkg::OP_SPD2; state_next = S_DIV;  end
            S_DIV:  begin cmd.op = ddwo_pkg::OP_DIV;  state_next = S_DIVW; end
            S_DIVW: begin
                if (!status.div_busy) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    cmd.op       = ddwo_pkg::OP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end
endmodule

>>> src/diff_drive_wheel_odometry_unit.sv
// Top level of the differential-drive wheel odometry unit.
`timescale 1ns / 1ps
// Each input beat carries left/right tick deltas and elapsed microseconds and yields one
// result beat with the pose, heading, speeds and tick totals. One beat is processed at a
// time: setup steps, 16 CORDIC iterations, the pose update, then the speed products and
// two parallel dividers, one per speed; when elapsed time is zero the speed steps are
// skipped. A finished result waits in the output register while the next beat is
// accepted; the next result stalls until it is taken. Configuration writes are always
// ready and belong between beats, with nothing in work.
module diff_drive_wheel_odometry_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ddwo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [23:0]                     cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [15:0]              s_left_tick_delta,
    input  logic signed [15:0]              s_right_tick_delta,
    input  logic [23:0]                     s_elapsed_us,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [39:0]              m_pose_x,
    output logic signed [39:0]              m_pose_y,
    output logic [15:0]                     m_heading_angle,
    output logic signed [31:0]              m_linear_speed,
    output logic signed [31:0]              m_angular_speed,
    output logic signed [47:0]              m_left_total,
    output logic signed [47:0]              m_right_total
);
    ddwo_pkg::cmd_t    cmd;
    ddwo_pkg::status_t status;

    assign cfg_ready = 1'b1;

    ddwo_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd), .status(status)
    );

    ddwo_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .status(status),
        .cfg_we(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_left_tick_delta(s_left_tick_delta), .s_right_tick_delta(s_right_tick_delta),
        .s_elapsed_us(s_elapsed_us), .m_pose_x(m_pose_x), .m_pose_y(m_pose_y),
        .m_heading_angle(m_heading_angle), .m_linear_speed(m_linear_speed),
        .m_angular_speed(m_angular_speed), .m_left_total(m_left_total),
        .m_right_total(m_right_total)
    );
endmodule

>>> src/ddwo_checker.sv
// Port-level assertions for the odometry unit, bound to the top level.
`timescale 1ns / 1ps
module ddwo_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [39:0] m_pose_x
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_pose_x))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a beat is in work");
endmodule

bind diff_drive_wheel_odometry_unit ddwo_checker u_ddwo_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_pose_x(m_pose_x)
);
